// ===== hdl/cct_pkg.sv =====
// Package for the chart curve lookup: formats, breakpoints, curve ROM and shared types.
package cct_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ARG_W     = 20;
    localparam int Y_W       = 16;
    localparam int X_W       = 16;
    localparam int OFF_W     = 13;
    localparam int RCP_W     = 32;
    localparam int RCP_SHIFT = 42;
    localparam int NUM_W     = 29;
    localparam int PROD_W    = NUM_W + RCP_W;
    localparam int Q_W       = 17;
    localparam int SEG_A_N   = 16;
    localparam int SEG_B_N   = 18;
    localparam int PTS       = 19;
    localparam int CURVES    = 12;
    localparam int LAT_LERP  = 3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NEG   = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ARG_NONE   = 2'd0,
        ARG_FIRST  = 2'd1,
        ARG_SECOND = 2'd2,
        ARG_THIRD  = 2'd3
    } arg_t;

    // Axis breakpoint g/40, rounded to nearest
    function automatic logic [X_W-1:0] grid_bp(input logic [5:0] g);
        logic [31:0] t;
        t = (32'(g) << FRAC_BITS) + 32'd20;
        return X_W'(t / 32'd40);
    endfunction

    // Breakpoint n/100, rounded to nearest
    function automatic logic [X_W-1:0] fx_pct(input logic [6:0] n);
        logic [31:0] t;
        t = (32'(n) << FRAC_BITS) + 32'd50;
        return X_W'(t / 32'd100);
    endfunction

    // Decimal sample (scaled by 1e9) to Q0.16, rounded to nearest
    function automatic logic [Y_W-1:0] q16(input longint unsigned n);
        logic [63:0] t;
        t = 64'(n) * 64'd65536 + 64'd500000000;
        return Y_W'(t / 64'd1000000000);
    endfunction

    // Axis breakpoints of the coarse grid (every 2/40) and of the fine grid
    localparam logic [X_W-1:0] BP_A [SEG_A_N+1] = '{
        grid_bp(6'd0), grid_bp(6'd2), grid_bp(6'd4), grid_bp(6'd6), grid_bp(6'd8),
        grid_bp(6'd10), grid_bp(6'd12), grid_bp(6'd14), grid_bp(6'd16), grid_bp(6'd18),
        grid_bp(6'd20), grid_bp(6'd22), grid_bp(6'd24), grid_bp(6'd26), grid_bp(6'd28),
        grid_bp(6'd30), grid_bp(6'd32)
    };

    localparam logic [X_W-1:0] BP_B [PTS] = '{
        grid_bp(6'd0), grid_bp(6'd1), grid_bp(6'd2), grid_bp(6'd3), grid_bp(6'd4),
        grid_bp(6'd6), grid_bp(6'd8), grid_bp(6'd10), grid_bp(6'd12), grid_bp(6'd14),
        grid_bp(6'd16), grid_bp(6'd18), grid_bp(6'd20), grid_bp(6'd22), grid_bp(6'd24),
        grid_bp(6'd26), grid_bp(6'd28), grid_bp(6'd30), grid_bp(6'd32)
    };

    localparam logic [X_W-1:0] X1_MAX  = fx_pct(7'd80);
    localparam logic [X_W-1:0] B_SEL0  = fx_pct(7'd4);
    localparam logic [X_W-1:0] B_SEL1  = fx_pct(7'd6);
    localparam logic [X_W-1:0] B_SEL2  = fx_pct(7'd9);
    localparam logic [X_W-1:0] B_SEL3  = fx_pct(7'd12);
    localparam logic [X_W-1:0] C_CH0   = fx_pct(7'd35);
    localparam logic [X_W-1:0] C_CH1   = fx_pct(7'd40);
    localparam logic [X_W-1:0] C_CH2   = fx_pct(7'd50);
    localparam logic [ARG_W-1:0] ONE_Q = ARG_W'(1 << FRAC_BITS);

    // Every segment width that occurs, and its reciprocal scaled by 2^RCP_SHIFT
    localparam logic [OFF_W-1:0] DIV0 = OFF_W'(grid_bp(6'd1) - grid_bp(6'd0));
    localparam logic [OFF_W-1:0] DIV1 = OFF_W'(grid_bp(6'd2) - grid_bp(6'd1));
    localparam logic [OFF_W-1:0] DIV2 = OFF_W'(grid_bp(6'd6) - grid_bp(6'd4));
    localparam logic [OFF_W-1:0] DIV3 = OFF_W'(grid_bp(6'd4) - grid_bp(6'd2));
    localparam logic [OFF_W-1:0] DIV4 = OFF_W'(B_SEL1 - B_SEL0);
    localparam logic [OFF_W-1:0] DIV5 = OFF_W'(B_SEL2 - B_SEL1);
    localparam logic [OFF_W-1:0] DIV6 = OFF_W'(C_CH2 - C_CH1);

    localparam logic [63:0] SCALE = 64'd1 << RCP_SHIFT;
    localparam logic [RCP_W-1:0] RCP0 = RCP_W'((SCALE + 64'(DIV0) - 64'd1) / 64'(DIV0));
    localparam logic [RCP_W-1:0] RCP1 = RCP_W'((SCALE + 64'(DIV1) - 64'd1) / 64'(DIV1));
    localparam logic [RCP_W-1:0] RCP2 = RCP_W'((SCALE + 64'(DIV2) - 64'd1) / 64'(DIV2));
    localparam logic [RCP_W-1:0] RCP3 = RCP_W'((SCALE + 64'(DIV3) - 64'd1) / 64'(DIV3));
    localparam logic [RCP_W-1:0] RCP4 = RCP_W'((SCALE + 64'(DIV4) - 64'd1) / 64'(DIV4));
    localparam logic [RCP_W-1:0] RCP5 = RCP_W'((SCALE + 64'(DIV5) - 64'd1) / 64'(DIV5));
    localparam logic [RCP_W-1:0] RCP6 = RCP_W'((SCALE + 64'(DIV6) - 64'd1) / 64'(DIV6));

    function automatic logic [RCP_W-1:0] rcp_of(input logic [OFF_W-1:0] d);
        unique case (d)
            DIV0:    return RCP0;
            DIV1:    return RCP1;
            DIV2:    return RCP2;
            DIV3:    return RCP3;
            DIV4:    return RCP4;
            DIV5:    return RCP5;
            DIV6:    return RCP6;
            default: return '0;
        endcase
    endfunction

    // Curve samples; rows 8 and 9 use the finer grid, other rows end at point 16
    localparam logic [Y_W-1:0] CURVE_Y [CURVES][PTS] = '{
        '{q16(873187494), q16(838098363), q16(786312549), q16(705389691), q16(616010242),
          q16(556528297), q16(509881929), q16(472314385), q16(441008098), q16(413771628),
          q16(390345584), q16(369731926), q16(351009348), q16(334138436), q16(319840579),
          q16(306909277), q16(296953878), 16'd0, 16'd0},
        '{q16(822330835), q16(807491657), q16(786312549), q16(749523849), q16(691366233),
          q16(627579676), q16(576837405), q16(535617462), q16(500397890), q16(470004705),
          q16(444039924), q16(420265993), q16(398416815), q16(380218771), q16(365836440),
          q16(354239984), q16(345893264), 16'd0, 16'd0},
        '{q16(758485565), q16(754709815), q16(747867274), q16(733779445), q16(709882307),
          q16(673619193), q16(628877293), q16(588961779), q16(552959550), q16(522044593),
          q16(492434065), q16(465693279), q16(440778693), q16(418342522), q16(394862807),
          q16(377513907), q16(363598666), 16'd0, 16'd0},
        '{q16(730348606), q16(725404316), q16(717734276), q16(706456889), q16(692682468),
          q16(677102553), q16(658099207), q16(635793479), q16(611791993), q16(585181650),
          q16(558310422), q16(529743436), q16(501176450), q16(471174593), q16(442677466),
          q16(417347157), q16(393454197), 16'd0, 16'd0},
        '{q16(874048100), q16(833759428), q16(750448122), q16(664283022), q16(599019932),
          q16(549864711), q16(507464739), q16(470783982), q16(438380864), q16(411431736),
          q16(384910373), q16(363522176), q16(342989507), q16(325647676), q16(310996761),
          q16(298155384), q16(286845988), 16'd0, 16'd0},
        '{q16(814049440), q16(801668239), q16(778568983), q16(742023439), q16(686253944),
          q16(632975232), q16(586028140), q16(543465629), q16(505822403), q16(472242935),
          q16(443888716), q16(419489085), q16(398292742), q16(382765326), q16(369938128),
          q16(358850485), q16(348317225), 16'd0, 16'd0},
        '{q16(768715020), q16(761674736), q16(750448122), q16(738875511), q16(715166696),
          q16(682371463), q16(639327719), q16(598155442), q16(560458747), q16(526326752),
          q16(495313868), q16(469024211), q16(447190428), q16(426069584), q16(410563142),
          q16(397246936), q16(388002764), 16'd0, 16'd0},
        '{q16(728635680), q16(723861836), q16(716932060), q16(707692358), q16(697528686),
          q16(683791748), q16(667581306), q16(647192978), q16(619248034), q16(584134874),
          q16(551302567), q16(521804681), q16(494891201), q16(468868897), q16(445876586),
          q16(430034684), q16(416549016), 16'd0, 16'd0},
        '{q16(895772379), q16(871303098), q16(812423895), q16(744674578), q16(690842164),
          q16(608564213), q16(547543948), q16(500593518), q16(464807198), q16(431314872),
          q16(402257603), q16(374729664), q16(351330915), q16(329614430), q16(309427275),
          q16(293552835), q16(280013761), q16(267328884), q16(256391689)},
        '{q16(840468041), q16(831842619), q16(817179725), q16(796215170), q16(769146029),
          q16(705067105), q16(641141113), q16(586544033), q16(536993743), q16(495548901),
          q16(459150849), q16(426117322), q16(400271646), q16(376872897), q16(357909206),
          q16(339404314), q16(324111014), q16(312029308), q16(301323998)},
        '{q16(786199559), q16(776428839), q16(762457824), q16(740425866), q16(713131577),
          q16(677447214), q16(633797592), q16(584412983), q16(540338547), q16(501680488),
          q16(465571311), q16(432011018), q16(400403824), q16(369775790), q16(345966616),
          q16(328144034), q16(314474647), 16'd0, 16'd0},
        '{q16(747525366), q16(747789635), q16(745729295), q16(740425866), q16(731276287),
          q16(718868187), q16(701981836), q16(678829482), q16(650366955), q16(612452319),
          q16(564448355), q16(519842902), q16(481715860), q16(447305939), q16(412896017),
          q16(386880424), q16(367328292), 16'd0, 16'd0}
    };

    typedef struct packed {
        logic             valid;
        status_t          status;
        arg_t             bad;
        logic [3:0]       seg_a;
        logic [4:0]       seg_b;
        logic [OFF_W-1:0] xoff_a;
        logic [OFF_W-1:0] dx_a;
        logic [OFF_W-1:0] xoff_b;
        logic [OFF_W-1:0] dx_b;
        logic [1:0]       seg_sel;
        logic [OFF_W-1:0] xoff_sel;
        logic [OFF_W-1:0] dx_sel;
        logic             seg_chart;
        logic [OFF_W-1:0] xoff_chart;
        logic [OFF_W-1:0] dx_chart;
    } front_t;

    typedef struct packed {
        status_t          status;
        arg_t             bad;
        logic [OFF_W-1:0] xoff_sel;
        logic [OFF_W-1:0] dx_sel;
        logic [OFF_W-1:0] xoff_chart;
        logic [OFF_W-1:0] dx_chart;
    } side_t;

    typedef struct packed {
        logic [Y_W-1:0]   ya;
        logic [Y_W-1:0]   yb;
        logic [OFF_W-1:0] xoff;
        logic [OFF_W-1:0] dx;
        logic [RCP_W-1:0] rcp;
    } lerp_op_t;

endpackage

// ===== hdl/cct_lerp.sv =====
// Three-stage linear interpolation unit with rounded division by a fixed segment width.
module cct_lerp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid_in,
    input  cct_pkg::lerp_op_t         op,
    output logic                      valid_out,
    output logic [cct_pkg::Y_W-1:0]   y
);

    logic signed [cct_pkg::Y_W:0]        diff;
    logic signed [30:0]                  num;
    logic [29:0]                         mag;
    logic [cct_pkg::NUM_W-1:0]           n_next;
    logic                                v1_reg, v2_reg, v3_reg;
    logic [cct_pkg::NUM_W-1:0]           n_reg;
    logic                                neg1_reg, neg2_reg;
    logic [cct_pkg::Y_W-1:0]             ya1_reg, ya2_reg;
    logic [cct_pkg::RCP_W-1:0]           rcp1_reg;
    logic [cct_pkg::PROD_W-1:0]          prod_reg;
    logic [cct_pkg::Q_W-1:0]             q;
    logic [cct_pkg::Y_W+1:0]             y_next;
    logic [cct_pkg::Y_W-1:0]             y_reg;

    // Stage 1: slope times offset, magnitude plus half width for rounding
    always_comb
    begin
        diff   = $signed({1'b0, op.yb}) - $signed({1'b0, op.ya});
        num    = diff * $signed({1'b0, op.xoff});
        mag    = num[30] ? 30'(-num) : 30'(num);
        n_next = cct_pkg::NUM_W'(mag) + cct_pkg::NUM_W'(op.dx >> 1);
    end

    // Stage 3: quotient back onto the lower sample
    always_comb
    begin
        q = prod_reg[cct_pkg::RCP_SHIFT +: cct_pkg::Q_W];
        if (neg2_reg)
            y_next = {2'b00, ya2_reg} - {1'b0, q};
        else
            y_next = {2'b00, ya2_reg} + {1'b0, q};
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Data stages
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        neg1_reg <= num[30];
        ya1_reg  <= op.ya;
        rcp1_reg <= op.rcp;
        prod_reg <= cct_pkg::PROD_W'(n_reg) * cct_pkg::PROD_W'(rcp1_reg);
        neg2_reg <= neg1_reg;
        ya2_reg  <= ya1_reg;
        y_reg    <= y_next[cct_pkg::Y_W-1:0];
    end

    assign valid_out = v3_reg;
    assign y         = y_reg;

endmodule

// ===== hdl/cct_front.sv =====
// Front stages: argument capture, checks and clamping, segment search and offsets.
module cct_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic signed [cct_pkg::ARG_W-1:0]  arg_curve_sel,
    input  logic signed [cct_pkg::ARG_W-1:0]  arg_axis,
    input  logic signed [cct_pkg::ARG_W-1:0]  arg_chart_sel,
    output cct_pkg::front_t                   front
);

    logic                              v1_reg, v2_reg;
    logic signed [cct_pkg::ARG_W-1:0]  a1_reg, a2_reg, a3_reg;
    cct_pkg::status_t                  st_next, st2_reg;
    cct_pkg::arg_t                     bad_next, bad2_reg;
    logic [cct_pkg::X_W-1:0]           x1_next, x2_next, x3_next;
    logic [cct_pkg::X_W-1:0]           x1_reg, x2_reg, x3_reg;
    cct_pkg::front_t                   front_next, front_reg;

    // Stage 2: checks in order, then clamp to the table ranges
    always_comb
    begin
        if (a1_reg[cct_pkg::ARG_W-1])
        begin
            st_next  = cct_pkg::ST_NEG;
            bad_next = cct_pkg::ARG_FIRST;
        end
        else if (a2_reg[cct_pkg::ARG_W-1])
        begin
            st_next  = cct_pkg::ST_NEG;
            bad_next = cct_pkg::ARG_SECOND;
        end
        else if (a3_reg[cct_pkg::ARG_W-1])
        begin
            st_next  = cct_pkg::ST_NEG;
            bad_next = cct_pkg::ARG_THIRD;
        end
        else if (a3_reg > $signed(cct_pkg::ONE_Q))
        begin
            st_next  = cct_pkg::ST_RANGE;
            bad_next = cct_pkg::ARG_THIRD;
        end
        else
        begin
            st_next  = cct_pkg::ST_OK;
            bad_next = cct_pkg::ARG_NONE;
        end

        if (a2_reg[cct_pkg::ARG_W-1])
            x1_next = '0;
        else if (a2_reg > $signed({4'd0, cct_pkg::X1_MAX}))
            x1_next = cct_pkg::X1_MAX;
        else
            x1_next = a2_reg[cct_pkg::X_W-1:0];

        if (a1_reg < $signed({4'd0, cct_pkg::B_SEL0}))
            x2_next = cct_pkg::B_SEL0;
        else if (a1_reg > $signed({4'd0, cct_pkg::B_SEL3}))
            x2_next = cct_pkg::B_SEL3;
        else
            x2_next = a1_reg[cct_pkg::X_W-1:0];

        if (a3_reg < $signed({4'd0, cct_pkg::C_CH0}))
            x3_next = cct_pkg::C_CH0;
        else if (a3_reg > $signed({4'd0, cct_pkg::C_CH2}))
            x3_next = cct_pkg::C_CH2;
        else
            x3_next = a3_reg[cct_pkg::X_W-1:0];
    end

    // Stage 3: segment on each axis and offset into it
    always_comb
    begin
        logic [3:0]              sa;
        logic [4:0]              sb;
        logic [cct_pkg::X_W-1:0] lo, hi;
        sa = '0;
        sb = '0;
        for (int j = 1; j < cct_pkg::SEG_A_N; j++)
        begin
            if (x1_reg >= cct_pkg::BP_A[j])
                sa = 4'(j);
        end
        for (int j = 1; j < cct_pkg::SEG_B_N; j++)
        begin
            if (x1_reg >= cct_pkg::BP_B[j])
                sb = 5'(j);
        end

        front_next.valid  = v2_reg;
        front_next.status = st2_reg;
        front_next.bad    = bad2_reg;
        front_next.seg_a  = sa;
        front_next.seg_b  = sb;

        lo = cct_pkg::BP_A[{1'b0, sa}];
        hi = cct_pkg::BP_A[{1'b0, sa} + 5'd1];
        front_next.xoff_a = cct_pkg::OFF_W'(x1_reg - lo);
        front_next.dx_a   = cct_pkg::OFF_W'(hi - lo);

        lo = cct_pkg::BP_B[sb];
        hi = cct_pkg::BP_B[sb + 5'd1];
        front_next.xoff_b = cct_pkg::OFF_W'(x1_reg - lo);
        front_next.dx_b   = cct_pkg::OFF_W'(hi - lo);

        priority if (x2_reg < cct_pkg::B_SEL1)
        begin
            front_next.seg_sel = 2'd0;
            lo = cct_pkg::B_SEL0;
            hi = cct_pkg::B_SEL1;
        end
        else if (x2_reg < cct_pkg::B_SEL2)
        begin
            front_next.seg_sel = 2'd1;
            lo = cct_pkg::B_SEL1;
            hi = cct_pkg::B_SEL2;
        end
        else
        begin
            front_next.seg_sel = 2'd2;
            lo = cct_pkg::B_SEL2;
            hi = cct_pkg::B_SEL3;
        end
        front_next.xoff_sel = cct_pkg::OFF_W'(x2_reg - lo);
        front_next.dx_sel   = cct_pkg::OFF_W'(hi - lo);

        if (x3_reg < cct_pkg::C_CH1)
        begin
            front_next.seg_chart = 1'b0;
            lo = cct_pkg::C_CH0;
            hi = cct_pkg::C_CH1;
        end
        else
        begin
            front_next.seg_chart = 1'b1;
            lo = cct_pkg::C_CH1;
            hi = cct_pkg::C_CH2;
        end
        front_next.xoff_chart = cct_pkg::OFF_W'(x3_reg - lo);
        front_next.dx_chart   = cct_pkg::OFF_W'(hi - lo);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            front_reg <= '0;
        end
        else
        begin
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            front_reg <= front_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        a1_reg   <= arg_curve_sel;
        a2_reg   <= arg_axis;
        a3_reg   <= arg_chart_sel;
        st2_reg  <= st_next;
        bad2_reg <= bad_next;
        x1_reg   <= x1_next;
        x2_reg   <= x2_next;
        x3_reg   <= x3_next;
    end

    assign front = front_reg;

endmodule

// ===== hdl/cct_fetch.sv =====
// Curve ROM stage: picks the four curves in play and reads both ends of each segment.
module cct_fetch (
    input  logic               clk,
    input  logic               rst_n,
    input  cct_pkg::front_t    front,
    output logic               valid_out,
    output cct_pkg::lerp_op_t  ops [4],
    output cct_pkg::side_t     side
);

    cct_pkg::lerp_op_t ops_next [4];
    cct_pkg::lerp_op_t ops_reg  [4];
    cct_pkg::side_t    side_reg;
    logic              v_reg;

    // Op k: chart seg_chart + k/2, curve seg_sel + k%2
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic [1:0] chart;
            logic [1:0] pos;
            logic [3:0] idx;
            logic       use_b;
            logic [4:0] seg;
            chart = {1'b0, front.seg_chart} + 2'(k / 2);
            pos   = front.seg_sel + 2'(k % 2);
            idx   = {chart, pos};
            use_b = (chart == 2'd2) && !pos[1];
            seg   = use_b ? front.seg_b : {1'b0, front.seg_a};
            ops_next[k].ya   = cct_pkg::CURVE_Y[idx][seg];
            ops_next[k].yb   = cct_pkg::CURVE_Y[idx][seg + 5'd1];
            ops_next[k].xoff = use_b ? front.xoff_b : front.xoff_a;
            ops_next[k].dx   = use_b ? front.dx_b : front.dx_a;
            ops_next[k].rcp  = cct_pkg::rcp_of(use_b ? front.dx_b : front.dx_a);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= front.valid;
    end

    always_ff @(posedge clk)
    begin
        ops_reg             <= ops_next;
        side_reg.status     <= front.status;
        side_reg.bad        <= front.bad;
        side_reg.xoff_sel   <= front.xoff_sel;
        side_reg.dx_sel     <= front.dx_sel;
        side_reg.xoff_chart <= front.xoff_chart;
        side_reg.dx_chart   <= front.dx_chart;
    end

    assign valid_out = v_reg;
    assign ops       = ops_reg;
    assign side      = side_reg;

endmodule

// ===== hdl/chart_curve_trilinear_interp_top.sv =====
// Top level of the three-argument chart lookup with trilinear interpolation.
//
// Use: drive arg_curve_sel, arg_axis and arg_chart_sel (signed Q3.16) and pulse
// start. A transaction is taken at every rising edge with start high; busy is
// always low, so one transaction can be issued in every cycle.
// Result: done is high for exactly one cycle with value (Q0.16), status and
// bad_arg; throughput is one per cycle. The pipeline holds three front stages
// (capture, check and clamp, segment search), one curve ROM stage, three
// interpolation levels of three stages each (multiply, reciprocal multiply,
// add) and an output register.
// status 1 flags a negative argument, status 2 a third argument above 1.0;
// bad_arg names the argument and value is then zero.
// Reset clears all valid bits; transactions in flight are dropped.
// The receiver cannot stall: each result must be taken in the cycle shown.
module chart_curve_trilinear_interp_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [cct_pkg::ARG_W-1:0]  arg_curve_sel,
    input  logic signed [cct_pkg::ARG_W-1:0]  arg_axis,
    input  logic signed [cct_pkg::ARG_W-1:0]  arg_chart_sel,
    output logic                              done,
    output logic [cct_pkg::Y_W-1:0]           value,
    output logic [1:0]                        status,
    output logic [1:0]                        bad_arg
);

    localparam int SIDE_D = 3 * cct_pkg::LAT_LERP;

    cct_pkg::front_t    front_w;
    logic               fetch_v;
    cct_pkg::lerp_op_t  curve_ops [4];
    cct_pkg::side_t     side_w;
    cct_pkg::side_t     side_pipe_reg [SIDE_D];
    logic [3:0]         curve_v;
    logic [cct_pkg::Y_W-1:0] curve_y [4];
    cct_pkg::lerp_op_t  sel_ops [2];
    logic [1:0]         sel_v;
    logic [cct_pkg::Y_W-1:0] sel_y [2];
    cct_pkg::lerp_op_t  chart_op;
    logic               chart_v;
    logic [cct_pkg::Y_W-1:0] chart_y;
    logic               done_reg;
    logic [cct_pkg::Y_W-1:0] value_reg;
    cct_pkg::status_t   status_reg;
    cct_pkg::arg_t      bad_reg;

    assign busy = 1'b0;

    cct_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (start && !busy),
        .arg_curve_sel (arg_curve_sel),
        .arg_axis      (arg_axis),
        .arg_chart_sel (arg_chart_sel),
        .front         (front_w)
    );

    cct_fetch u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .front     (front_w),
        .valid_out (fetch_v),
        .ops       (curve_ops),
        .side      (side_w)
    );

    // Side information travels alongside the interpolation levels
    always_ff @(posedge clk)
    begin
        side_pipe_reg[0] <= side_w;
        for (int i = 1; i < SIDE_D; i++)
            side_pipe_reg[i] <= side_pipe_reg[i-1];
    end

    // Level 1: along the curve axis, four curves
    for (genvar k = 0; k < 4; k++)
    begin : g_curve
        cct_lerp u_curve_lerp (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (fetch_v),
            .op        (curve_ops[k]),
            .valid_out (curve_v[k]),
            .y         (curve_y[k])
        );
    end

    // Level 2: between neighbouring curves of each chart
    for (genvar k = 0; k < 2; k++)
    begin : g_sel
        always_comb
        begin
            sel_ops[k].ya   = curve_y[2*k];
            sel_ops[k].yb   = curve_y[2*k+1];
            sel_ops[k].xoff = side_pipe_reg[cct_pkg::LAT_LERP-1].xoff_sel;
            sel_ops[k].dx   = side_pipe_reg[cct_pkg::LAT_LERP-1].dx_sel;
            sel_ops[k].rcp  = cct_pkg::rcp_of(side_pipe_reg[cct_pkg::LAT_LERP-1].dx_sel);
        end

        cct_lerp u_sel_lerp (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (curve_v[2*k]),
            .op        (sel_ops[k]),
            .valid_out (sel_v[k]),
            .y         (sel_y[k])
        );
    end

    // Level 3: between neighbouring charts
    always_comb
    begin
        chart_op.ya   = sel_y[0];
        chart_op.yb   = sel_y[1];
        chart_op.xoff = side_pipe_reg[2*cct_pkg::LAT_LERP-1].xoff_chart;
        chart_op.dx   = side_pipe_reg[2*cct_pkg::LAT_LERP-1].dx_chart;
        chart_op.rcp  = cct_pkg::rcp_of(side_pipe_reg[2*cct_pkg::LAT_LERP-1].dx_chart);
    end

    cct_lerp u_chart_lerp (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sel_v[0] && sel_v[1]),
        .op        (chart_op),
        .valid_out (chart_v),
        .y         (chart_y)
    );

    // Output register; value forced to zero on a failed check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chart_v;
    end

    always_ff @(posedge clk)
    begin
        status_reg <= side_pipe_reg[SIDE_D-1].status;
        bad_reg    <= side_pipe_reg[SIDE_D-1].bad;
        if (side_pipe_reg[SIDE_D-1].status == cct_pkg::ST_OK)
            value_reg <= chart_y;
        else
            value_reg <= '0;
    end

    assign done    = done_reg;
    assign value   = value_reg;
    assign status  = status_reg;
    assign bad_arg = bad_reg;

endmodule

// ===== hdl/cct_checker.sv =====
// Port-level checker for the chart lookup, bound to the top level.
module cct_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [cct_pkg::Y_W-1:0]         value,
    input logic [1:0]                      status,
    input logic [1:0]                      bad_arg
);

    // Every result stems from a transaction accepted earlier, at the depth of the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 14))
        else $error("result without a matching transaction");

    // status and bad_arg agree on whether the transaction passed its checks
    a_status_arg: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == cct_pkg::ST_OK) == (bad_arg == cct_pkg::ARG_NONE)))
        else $error("status and bad_arg disagree");

    // A failed check returns zero
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != cct_pkg::ST_OK) |-> (value == '0))
        else $error("nonzero value on failed check");

    // Range failure only concerns the third argument
    a_range_arg: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == cct_pkg::ST_RANGE) |-> (bad_arg == cct_pkg::ARG_THIRD))
        else $error("range failure names wrong argument");

endmodule

bind chart_curve_trilinear_interp_top cct_checker u_cct_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .value   (value),
    .status  (status),
    .bad_arg (bad_arg)
);

// ===== tb/sv/chart_curve_trilinear_interp_checker.sv =====
// Checker for the chart lookup: predicts each transaction's result and compares it on done.
module chart_curve_trilinear_interp_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic signed [cct_pkg::ARG_W-1:0] arg_curve_sel,
    input  logic signed [cct_pkg::ARG_W-1:0] arg_axis,
    input  logic signed [cct_pkg::ARG_W-1:0] arg_chart_sel,
    input  logic                             done,
    input  logic [cct_pkg::Y_W-1:0]          value,
    input  logic [1:0]                       status,
    input  logic [1:0]                       bad_arg,
    output int                               errors,
    output int                               outstanding
);
    import cct_pkg::*;

    typedef struct {
        logic [15:0] val;
        status_t     st;
        arg_t        bad;
    } lookup_res_t;

    lookup_res_t pending_q[$];

    localparam int FINE_GRID [19] = '{0, 1, 2, 3, 4, 6, 8, 10, 12, 14, 16, 18, 20, 22, 24, 26,
                                      28, 30, 32};

    // Curve samples as decimals scaled by 1e9
    localparam longint SAMPLE_DEC [12][19] = '{
        '{873187494, 838098363, 786312549, 705389691, 616010242, 556528297, 509881929,
          472314385, 441008098, 413771628, 390345584, 369731926, 351009348, 334138436,
          319840579, 306909277, 296953878, 0, 0},
        '{822330835, 807491657, 786312549, 749523849, 691366233, 627579676, 576837405,
          535617462, 500397890, 470004705, 444039924, 420265993, 398416815, 380218771,
          365836440, 354239984, 345893264, 0, 0},
        '{758485565, 754709815, 747867274, 733779445, 709882307, 673619193, 628877293,
          588961779, 552959550, 522044593, 492434065, 465693279, 440778693, 418342522,
          394862807, 377513907, 363598666, 0, 0},
        '{730348606, 725404316, 717734276, 706456889, 692682468, 677102553, 658099207,
          635793479, 611791993, 585181650, 558310422, 529743436, 501176450, 471174593,
          442677466, 417347157, 393454197, 0, 0},
        '{874048100, 833759428, 750448122, 664283022, 599019932, 549864711, 507464739,
          470783982, 438380864, 411431736, 384910373, 363522176, 342989507, 325647676,
          310996761, 298155384, 286845988, 0, 0},
        '{814049440, 801668239, 778568983, 742023439, 686253944, 632975232, 586028140,
          543465629, 505822403, 472242935, 443888716, 419489085, 398292742, 382765326,
          369938128, 358850485, 348317225, 0, 0},
        '{768715020, 761674736, 750448122, 738875511, 715166696, 682371463, 639327719,
          598155442, 560458747, 526326752, 495313868, 469024211, 447190428, 426069584,
          410563142, 397246936, 388002764, 0, 0},
        '{728635680, 723861836, 716932060, 707692358, 697528686, 683791748, 667581306,
          647192978, 619248034, 584134874, 551302567, 521804681, 494891201, 468868897,
          445876586, 430034684, 416549016, 0, 0},
        '{895772379, 871303098, 812423895, 744674578, 690842164, 608564213, 547543948,
          500593518, 464807198, 431314872, 402257603, 374729664, 351330915, 329614430,
          309427275, 293552835, 280013761, 267328884, 256391689},
        '{840468041, 831842619, 817179725, 796215170, 769146029, 705067105, 641141113,
          586544033, 536993743, 495548901, 459150849, 426117322, 400271646, 376872897,
          357909206, 339404314, 324111014, 312029308, 301323998},
        '{786199559, 776428839, 762457824, 740425866, 713131577, 677447214, 633797592,
          584412983, 540338547, 501680488, 465571311, 432011018, 400403824, 369775790,
          345966616, 328144034, 314474647, 0, 0},
        '{747525366, 747789635, 745729295, 740425866, 731276287, 718868187, 701981836,
          678829482, 650366955, 612452319, 564448355, 519842902, 481715860, 447305939,
          412896017, 386880424, 367328292, 0, 0}
    };

    // num/den with 16 fraction bits, rounded to nearest
    function automatic longint to_fix(input longint num, input longint den);
        return ((num << 16) + den / 2) / den;
    endfunction

    function automatic longint sample_q16(input int row, input int pt);
        return (SAMPLE_DEC[row][pt] * 65536 + 500000000) / 1000000000;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Linear step, quotient rounded to nearest with ties away from zero
    function automatic longint lerp_round(input longint xa, input longint ya,
                                          input longint xb, input longint yb,
                                          input longint x);
        longint dx, num, q;
        dx  = xb - xa;
        num = (yb - ya) * (x - xa);
        if (dx <= 0) return ya;
        if (num < 0) q = -(((-num) + dx / 2) / dx);
        else         q = (num + dx / 2) / dx;
        return ya + q;
    endfunction

    function automatic longint axis_point(input bit fine, input int i);
        return to_fix(fine ? FINE_GRID[i] : 2 * i, 40);
    endfunction

    function automatic longint curve_value(input int row, input longint x);
        bit fine;
        int n, i;
        fine = (row == 8 || row == 9);
        n    = fine ? 19 : 17;
        i    = 0;
        while (i < n - 2 && axis_point(fine, i + 1) <= x) i++;
        return lerp_round(axis_point(fine, i), sample_q16(row, i),
                          axis_point(fine, i + 1), sample_q16(row, i + 1), x);
    endfunction

    function automatic longint chart_value(input int chart, input longint xc, input longint xa);
        longint bp [4];
        int s;
        bp[0] = to_fix(4, 100);
        bp[1] = to_fix(6, 100);
        bp[2] = to_fix(9, 100);
        bp[3] = to_fix(12, 100);
        xc = clip(xc, bp[0], bp[3]);
        s  = (xc < bp[1]) ? 0 : ((xc < bp[2]) ? 1 : 2);
        return lerp_round(bp[s], curve_value(chart * 4 + s, xa),
                          bp[s + 1], curve_value(chart * 4 + s + 1, xa), xc);
    endfunction

    function automatic lookup_res_t chart_lookup(input logic signed [ARG_W-1:0] r1,
                                                 input logic signed [ARG_W-1:0] r2,
                                                 input logic signed [ARG_W-1:0] r3);
        lookup_res_t r;
        longint a1, a2, a3, xa, xh, y;
        longint cp [3];
        int s;
        a1 = r1;
        a2 = r2;
        a3 = r3;
        r.val = '0;
        r.st  = ST_OK;
        r.bad = ARG_NONE;
        if (a1 < 0) begin
            r.st = ST_NEG; r.bad = ARG_FIRST;
        end else if (a2 < 0) begin
            r.st = ST_NEG; r.bad = ARG_SECOND;
        end else if (a3 < 0) begin
            r.st = ST_NEG; r.bad = ARG_THIRD;
        end else if (a3 > to_fix(1, 1)) begin
            r.st = ST_RANGE; r.bad = ARG_THIRD;
        end
        if (r.st != ST_OK) return r;
        cp[0] = to_fix(35, 100);
        cp[1] = to_fix(40, 100);
        cp[2] = to_fix(50, 100);
        xa = clip(a2, 0, to_fix(80, 100));
        xh = clip(a3, cp[0], cp[2]);
        s  = (xh < cp[1]) ? 0 : 1;
        y  = lerp_round(cp[s], chart_value(s, a1, xa), cp[s + 1], chart_value(s + 1, a1, xa), xh);
        r.val = 16'(clip(y, 0, 65535));
        return r;
    endfunction

    task automatic report(input string what, input longint exp_v, input longint got_v);
        $display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    initial begin
        errors = 0;
    end

    assign outstanding = pending_q.size();

    // Predict on every accepted transaction, compare on every result
    always @(posedge clk) begin
        lookup_res_t e;
        if (rst_n) begin
            if (done) begin
                if (pending_q.size() == 0) begin
                    report("unexpected result, value", -1, value);
                end else begin
                    e = pending_q.pop_front();
                    if (value !== e.val) report("value", e.val, value);
                    if (status !== e.st) report("status", e.st, status);
                    if (bad_arg !== e.bad) report("bad_arg", e.bad, bad_arg);
                end
            end
            if (start && !busy)
                pending_q.push_back(chart_lookup(arg_curve_sel, arg_axis, arg_chart_sel));
        end
    end

endmodule

// ===== tb/sv/chart_curve_trilinear_interp_top_tb.sv =====
// Testbench top for the chart lookup: clock, reset, stimulus and verdict.
module chart_curve_trilinear_interp_top_tb;
    import cct_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [ARG_W-1:0] arg_curve_sel;
    logic signed [ARG_W-1:0] arg_axis;
    logic signed [ARG_W-1:0] arg_chart_sel;
    logic                    done;
    logic [Y_W-1:0]          value;
    logic [1:0]              status;
    logic [1:0]              bad_arg;
    int                      errors;
    int                      outstanding;
    int                      idle_pct;

    localparam int ONE_FIX = 65536;
    localparam int SEL_BP [4]   = '{2621, 3932, 5898, 7864};
    localparam int CHART_BP [4] = '{22938, 26214, 32768, 65536};
    localparam int FINE_G [19]  = '{0, 1, 2, 3, 4, 6, 8, 10, 12, 14, 16, 18, 20, 22, 24, 26,
                                    28, 30, 32};

    chart_curve_trilinear_interp_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .arg_curve_sel(arg_curve_sel), .arg_axis(arg_axis), .arg_chart_sel(arg_chart_sel),
        .done(done), .value(value), .status(status), .bad_arg(bad_arg)
    );

    chart_curve_trilinear_interp_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .arg_curve_sel(arg_curve_sel), .arg_axis(arg_axis), .arg_chart_sel(arg_chart_sel),
        .done(done), .value(value), .status(status), .bad_arg(bad_arg),
        .errors(errors), .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Present one transaction from a falling edge until it is taken, then idle
    // each following cycle with probability idle_pct percent
    task automatic issue(input int a1, input int a2, input int a3);
        start         <= 1'b1;
        arg_curve_sel <= ARG_W'(a1);
        arg_axis      <= ARG_W'(a2);
        arg_chart_sel <= ARG_W'(a3);
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    function automatic int axis_bp(input int g);
        return (g * 65536 + 20) / 40;
    endfunction

    // Mostly in-range triples, some on breakpoints, the rest raw 20-bit noise
    task automatic random_item();
        int r, a1, a2, a3;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            a1 = $urandom_range(0, 9830);
            a2 = $urandom_range(0, 58982);
            a3 = $urandom_range(0, 72090);
        end
        else if (r < 85)
        begin
            a1 = SEL_BP[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1;
            a2 = axis_bp(FINE_G[$urandom_range(0, 18)]) + $urandom_range(0, 2) - 1;
            a3 = CHART_BP[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1;
            if (a1 < 0) a1 = 0;
            if (a2 < 0) a2 = 0;
        end
        else
        begin
            a1 = $urandom;
            a2 = $urandom;
            a3 = $urandom;
            if (r < 92)
            begin
                a1 = a1 & 32'h7FFFF;
                a2 = a2 & 32'h7FFFF;
            end
        end
        issue(a1, a2, a3);
    endtask

    initial
    begin
        #2000000;
        $display("chart_curve_trilinear_interp_top verification failed");
        $finish;
    end

    initial
    begin
        int phase_pct [4];
        phase_pct = '{0, 51, 0, 9};
        rst_n         = 1'b0;
        start         = 1'b0;
        arg_curve_sel = '0;
        arg_axis      = '0;
        arg_chart_sel = '0;
        idle_pct      = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, each check, breakpoints and clamping
        issue(0, 0, 0);
        issue(524287, 524287, 524287);
        issue(-524288, 0, 0);
        issue(0, -524288, 0);
        issue(0, 0, -524288);
        issue(-1, -1, -1);
        issue(3000, -1, 40000);
        issue(3000, 20000, -1);
        issue(3000, 20000, ONE_FIX);
        issue(3000, 20000, ONE_FIX + 1);
        issue(SEL_BP[0], 0, CHART_BP[0]);
        issue(SEL_BP[1], axis_bp(1), CHART_BP[1]);
        issue(SEL_BP[2], axis_bp(4), CHART_BP[2]);
        issue(SEL_BP[3], axis_bp(32), CHART_BP[2]);
        issue(SEL_BP[3], axis_bp(30), CHART_BP[1]);
        issue(SEL_BP[0] - 1, axis_bp(32) + 1, CHART_BP[0] - 1);
        issue(SEL_BP[3] + 1, axis_bp(31), CHART_BP[2] + 1);
        issue(1000, 30000, 10000);
        issue(200000, 400000, 60000);
        issue(4500, 1, 24000);
        issue(7000, 45000, 30000);
        issue(5000, 52428, 28000);

        // Random phases, the idle rate set per phase from phase_pct
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_pct[p];
            for (int i = 0; i < 125; i++) random_item();
        end
        start <= 1'b0;

        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("chart_curve_trilinear_interp_top verification clean");
        else
            $display("chart_curve_trilinear_interp_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/cct_pkg.sv
hdl/cct_lerp.sv
hdl/cct_front.sv
hdl/cct_fetch.sv
hdl/chart_curve_trilinear_interp_top.sv
hdl/cct_checker.sv
tb/sv/chart_curve_trilinear_interp_checker.sv
tb/sv/chart_curve_trilinear_interp_top_tb.sv
